FILE: design/alu816_pkg.sv
package alu816_pkg;

    // Operation codes carried in the low five bits of each request.
    typedef enum logic [4:0] {
        FN_ADC = 5'd0,
        FN_AND = 5'd1,
        FN_BIT = 5'd2,
        FN_CMP = 5'd3,
        FN_CPX = 5'd4,
        FN_CPY = 5'd5,
        FN_EOR = 5'd6,
        FN_LDA = 5'd7,
        FN_LDX = 5'd8,
        FN_LDY = 5'd9,
        FN_ORA = 5'd10,
        FN_SBC = 5'd11,
        FN_INC = 5'd12,
        FN_DEC = 5'd13,
        FN_ASL = 5'd14,
        FN_LSR = 5'd15,
        FN_ROL = 5'd16,
        FN_ROR = 5'd17,
        FN_TRB = 5'd18,
        FN_TSB = 5'd19
    } alu_func_t;

    localparam logic [15:0] MASK_W16 = 16'hffff;
    localparam logic [15:0] MASK_W8  = 16'h00ff;
    localparam logic [15:0] SIGN_W16 = 16'h8000;
    localparam logic [15:0] SIGN_W8  = 16'h0080;

    // One request. The first member is the most significant, so the packed
    // struct lines up with the stream word: func sits in the lowest bits.
    typedef struct packed {
        logic        zero_in;
        logic        ovf_in;
        logic        neg_in;
        logic        carry_in;
        logic [15:0] operand;
        logic [15:0] index_in;
        logic [15:0] acc_in;
        logic        decimal;
        logic        wide;
        logic [4:0]  func;
    } alu_req_t;

    // One result, acc_out in the lowest bits.
    typedef struct packed {
        logic        flag_c;
        logic        flag_z;
        logic        flag_v;
        logic        flag_n;
        logic [15:0] value_out;
        logic [15:0] index_out;
        logic [15:0] acc_out;
    } alu_res_t;

    // Controls of the shared adder.
    typedef struct packed {
        logic wide;
        logic decimal;
        logic sub;
        logic cin;
    } add_ctrl_t;

    localparam int REQ_W     = $bits(alu_req_t);
    localparam int RES_W     = $bits(alu_res_t);
    localparam int IN_DATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    // Sign bit of a value at the selected width.
    function automatic logic sign_of(input logic [15:0] v, input logic wide);
        return wide ? v[15] : v[7];
    endfunction

endpackage

FILE: design/alu816_adder.sv
module alu816_adder
    import alu816_pkg::*;
(
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  add_ctrl_t   ctrl,
    output logic [15:0] sum,
    output logic        ovf,
    output logic        carry
);

    logic [16:0] bin_sum;
    logic [4:0]  nib_sum [4];
    logic [4:0]  nib_cy;
    logic [15:0] dec_sum;
    logic [5:0]  nib_adj;
    logic        dec_top_raw;
    logic        top_raw;

    assign bin_sum = {1'b0, a} + {1'b0, b} + {16'd0, ctrl.cin};

    // Decimal mode: each nibble is added and then corrected, the carry
    // ripples through the four digits.
    always_comb
    begin
        nib_cy[0] = ctrl.cin;
        dec_sum   = '0;
        nib_adj   = '0;
        for (int k = 0; k < 4; k++)
        begin
            nib_sum[k] = {1'b0, a[4*k +: 4]} + {1'b0, b[4*k +: 4]} + {4'd0, nib_cy[k]};
            if (!ctrl.sub)
            begin
                nib_adj = {1'b0, nib_sum[k]} + ((nib_sum[k] >= 5'd10) ? 6'd6 : 6'd0);
                nib_cy[k+1] = (nib_adj[5:4] != 2'b00);
                dec_sum[4*k +: 4] = nib_adj[3:0];
            end
            else
            begin
                nib_cy[k+1] = nib_sum[k][4];
                dec_sum[4*k +: 4] = nib_sum[k][4] ? nib_sum[k][3:0]
                                                  : (nib_sum[k][3:0] - 4'd6);
            end
        end
    end

    // Overflow follows the top digit before its decimal correction.
    assign dec_top_raw = ctrl.wide ? nib_sum[3][3] : nib_sum[1][3];
    assign top_raw     = ctrl.decimal ? dec_top_raw : sign_of(bin_sum[15:0], ctrl.wide);

    assign ovf = ~(sign_of(a, ctrl.wide) ^ sign_of(b, ctrl.wide))
               & (sign_of(a, ctrl.wide) ^ top_raw);

    always_comb
    begin
        if (ctrl.decimal)
        begin
            carry = ctrl.wide ? nib_cy[4] : nib_cy[2];
            sum   = dec_sum & (ctrl.wide ? MASK_W16 : MASK_W8);
        end
        else
        begin
            carry = ctrl.wide ? bin_sum[16] : bin_sum[8];
            sum   = bin_sum[15:0] & (ctrl.wide ? MASK_W16 : MASK_W8);
        end
    end

endmodule

FILE: design/alu816_core.sv
module alu816_core
    import alu816_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    typedef enum logic [1:0] {
        TGT_NONE,
        TGT_ACC,
        TGT_INDEX,
        TGT_VALUE
    } target_t;

    logic [15:0] mask;
    logic [15:0] sign_mask;
    logic [15:0] a_val;
    logic [15:0] x_val;
    logic [15:0] m_val;
    logic [15:0] add_b;
    logic [15:0] add_sum;
    logic        add_v;
    logic        add_c;
    add_ctrl_t   add_ctrl;
    logic [15:0] cmp_src;
    logic [16:0] cmp_diff;
    alu_func_t   fn_code;
    target_t     target;
    logic [15:0] r_raw;
    logic [15:0] r_val;

    assign fn_code   = alu_func_t'(req.func);
    assign mask      = req.wide ? MASK_W16 : MASK_W8;
    assign sign_mask = req.wide ? SIGN_W16 : SIGN_W8;
    assign a_val     = req.acc_in & mask;
    assign x_val     = req.index_in & mask;
    assign m_val     = req.operand & mask;

    // Subtract feeds the inverted operand to the same adder.
    assign add_ctrl.wide    = req.wide;
    assign add_ctrl.decimal = req.decimal;
    assign add_ctrl.sub     = (fn_code == FN_SBC);
    assign add_ctrl.cin     = req.carry_in;
    assign add_b = add_ctrl.sub ? (~m_val & mask) : m_val;

    alu816_adder u_adder (
        .a     (a_val),
        .b     (add_b),
        .ctrl  (add_ctrl),
        .sum   (add_sum),
        .ovf   (add_v),
        .carry (add_c)
    );

    assign cmp_src  = (fn_code == FN_CMP) ? a_val : x_val;
    assign cmp_diff = {1'b0, cmp_src} - {1'b0, m_val};

    always_comb
    begin
        res.acc_out   = req.acc_in;
        res.index_out = req.index_in;
        res.value_out = req.operand;
        res.flag_n    = req.neg_in;
        res.flag_v    = req.ovf_in;
        res.flag_z    = req.zero_in;
        res.flag_c    = req.carry_in;
        r_raw         = '0;
        target        = TGT_NONE;

        case (fn_code)
            FN_ADC, FN_SBC:
            begin
                r_raw      = add_sum;
                res.flag_v = add_v;
                res.flag_c = add_c;
                target     = TGT_ACC;
            end
            FN_AND:
            begin
                r_raw  = a_val & m_val;
                target = TGT_ACC;
            end
            FN_EOR:
            begin
                r_raw  = a_val ^ m_val;
                target = TGT_ACC;
            end
            FN_ORA:
            begin
                r_raw  = a_val | m_val;
                target = TGT_ACC;
            end
            FN_LDA:
            begin
                r_raw  = m_val;
                target = TGT_ACC;
            end
            FN_LDX, FN_LDY:
            begin
                r_raw  = m_val;
                target = TGT_INDEX;
            end
            FN_BIT:
            begin
                res.flag_n = sign_of(m_val, req.wide);
                res.flag_v = req.wide ? m_val[14] : m_val[6];
                res.flag_z = ((m_val & a_val) == 16'd0);
            end
            FN_CMP, FN_CPX, FN_CPY:
            begin
                res.flag_n = sign_of(cmp_diff[15:0], req.wide);
                res.flag_z = (cmp_src == m_val);
                res.flag_c = ~cmp_diff[16];
            end
            FN_INC:
            begin
                r_raw  = m_val + 16'd1;
                target = TGT_VALUE;
            end
            FN_DEC:
            begin
                r_raw  = m_val - 16'd1;
                target = TGT_VALUE;
            end
            FN_ASL:
            begin
                res.flag_c = sign_of(m_val, req.wide);
                r_raw      = {m_val[14:0], 1'b0};
                target     = TGT_VALUE;
            end
            FN_LSR:
            begin
                res.flag_c = m_val[0];
                r_raw      = {1'b0, m_val[15:1]};
                target     = TGT_VALUE;
            end
            FN_ROL:
            begin
                res.flag_c = sign_of(m_val, req.wide);
                r_raw      = {m_val[14:0], req.carry_in};
                target     = TGT_VALUE;
            end
            FN_ROR:
            begin
                res.flag_c = m_val[0];
                r_raw      = {1'b0, m_val[15:1]} | (req.carry_in ? sign_mask : 16'd0);
                target     = TGT_VALUE;
            end
            FN_TRB:
            begin
                res.flag_z    = ((m_val & a_val) == 16'd0);
                res.value_out = (req.operand & ~mask) | (m_val & ~a_val & mask);
            end
            FN_TSB:
            begin
                res.flag_z    = ((m_val & a_val) == 16'd0);
                res.value_out = (req.operand & ~mask) | ((m_val | a_val) & mask);
            end
            default:
            begin
                // Unused codes leave every value and flag as it came in.
                target = TGT_NONE;
            end
        endcase

        r_val = r_raw & mask;
        if (target != TGT_NONE)
        begin
            res.flag_n = sign_of(r_val, req.wide);
            res.flag_z = (r_val == 16'd0);
        end

        case (target)
            TGT_ACC:   res.acc_out   = (req.acc_in & ~mask) | r_val;
            TGT_INDEX: res.index_out = (req.index_in & ~mask) | r_val;
            TGT_VALUE: res.value_out = (req.operand & ~mask) | r_val;
            default:   ;
        endcase
    end

endmodule

FILE: design/alu_8_16_bit_with_bcd.sv
// ALU of an 8/16-bit processor with binary and BCD add and subtract.
//
// A request enters on the s_axis channel and carries the operation code, the
// width, the decimal flag, the accumulator, an index register, the operand and
// the incoming N, V, Z and C flags. The matching result leaves on the m_axis
// channel with the new accumulator, index register, read-modify-write value
// and the four flags. Every request produces exactly one result, in order.
//
// A request is held in the input register, then the combinational ALU feeds
// the result register. The block takes one request per cycle for as long as
// the receiver keeps up.
//
// When the receiver stalls, the result register holds its word and the input
// register can still take one more request; after that s_axis_tready drops
// until the result is taken. Nothing is lost or repeated.
//
// Reset empties both stages; the block holds no other state and is ready for
// a request as soon as reset is released.
module alu_8_16_bit_with_bcd
    import alu816_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0 up: func[4:0], wide, decimal, acc_in[15:0],
    // index_in[15:0], operand[15:0], carry_in, neg_in, ovf_in, zero_in, zeros.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0 up: acc_out[15:0], index_out[15:0], value_out[15:0],
    // flag_n, flag_v, flag_z, flag_c, zeros.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic     in_valid_reg;
    logic     in_valid_next;
    alu_req_t in_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    alu_res_t out_reg;
    alu_res_t core_res;
    logic     advance;
    logic     accept;

    // The result register can load whenever it is empty or being drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= alu_req_t'(s_axis_tdata[REQ_W-1:0]);
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= core_res;
        end
    end

    alu816_core u_core (
        .req (in_reg),
        .res (core_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_reg};

`ifndef SYNTHESIS
    // A waiting request is never dropped while the result register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending request lost during output stall");

    // An empty input stage always takes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input refused while input stage empty");

    // A request that moves forward shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> m_axis_tvalid)
        else $error("result missing after stage advance");

    // With nothing in flight no result appears out of nowhere.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid_reg && advance) |=> !m_axis_tvalid)
        else $error("spurious result");

    // In 8-bit mode the high byte of the accumulator passes through.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance && !in_reg.wide)
            |=> (m_axis_tdata[15:8] == $past(in_reg.acc_in[15:8])))
        else $error("accumulator high byte changed in 8-bit mode");
`endif

endmodule
